// ----- hw/rtl/kbf_pkg.sv -----
// ----------------------------------------------------------------------------
// kbf_pkg
// Shared types and constants of the keyboard buffer with foreground owner:
// item structs, operation codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package kbf_pkg;

  localparam int unsigned KBF_FIFO_DEPTH = 256;
  localparam int unsigned KBF_TASK_LIMIT = 64;

  localparam logic [2:0] OP_PUSH     = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_SET_OPER = 3'd2;
  localparam logic [2:0] OP_SET_FG   = 3'd3;
  localparam logic [2:0] OP_SWITCH   = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] char_value;
    logic [7:0] pid;
    logic       pid_none;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       data_valid;
    logic [7:0] char_out;
    logic       wake_valid;
    logic [7:0] wake_pid;
    logic       foreground_valid;
    logic [7:0] foreground_task;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic push;
    logic inst_pid;
    logic inst_oper;
    logic set_oper;
    logic fifo_take;
    logic pop_rd;
    logic pop_take;
    logic srch_start;
    logic srch_step;
    logic append;
    logic err;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pid_none;
    logic       pid_ok;
    logic       owner_set;
    logic       owner_match;
    logic       fifo_empty;
    logic       wait_any;
    logic       oper_set;
    logic       srch_hit;
    logic       srch_done;
  } sts_t;

endpackage

// ----- hw/rtl/kbf_dpath.sv -----
// ----------------------------------------------------------------------------
// kbf_dpath
// Datapath: character FIFO memory and pointers, owner and operator
// registers, circular waiting list with pipelined duplicate search,
// result accumulation and output register.
// ----------------------------------------------------------------------------
module kbf_dpath #(
  parameter int unsigned FIFO_DEPTH = kbf_pkg::KBF_FIFO_DEPTH,
  parameter int unsigned TASK_LIMIT = kbf_pkg::KBF_TASK_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kbf_pkg::in_item_t  in_data,
  input  kbf_pkg::cmd_t      cmd,
  output kbf_pkg::sts_t      sts,
  output kbf_pkg::out_item_t out_data
);

  localparam int unsigned FA = $clog2(FIFO_DEPTH);
  localparam int unsigned WA = $clog2(TASK_LIMIT);
  localparam int unsigned CW = $clog2(TASK_LIMIT + 1);
  localparam logic [FA-1:0] FIFO_LAST = FA'(FIFO_DEPTH - 1);
  localparam logic [WA-1:0] WAIT_LAST = WA'(TASK_LIMIT - 1);
  localparam logic [CW-1:0] WAIT_FULL = CW'(TASK_LIMIT);
  localparam logic [CW:0]   TAIL_LIM  = (CW + 1)'(TASK_LIMIT);
  localparam logic [8:0]    PID_LIM   = 9'(TASK_LIMIT);

  kbf_pkg::in_item_t  item_r;
  kbf_pkg::out_item_t out_r;

  logic [7:0]    fifo_mem [FIFO_DEPTH];
  logic [7:0]    fifo_rdata_r;
  logic [FA-1:0] wr_idx_r, rd_idx_r, wr_idx_inc, rd_idx_inc;
  logic          wr_ph_r, rd_ph_r;
  logic          fifo_empty, fifo_full;

  logic [7:0]    owner_r, oper_r;
  logic          owner_set_r, oper_set_r;

  logic [7:0]    wait_mem [TASK_LIMIT];
  logic [7:0]    wait_rdata_r;
  logic [WA-1:0] head_r, sptr_r, head_inc, sptr_inc, tail, wait_raddr;
  logic [CW-1:0] count_r, issued_r;
  logic [CW:0]   tail_sum;
  logic          cmp_vld_r, wait_full, popped_ok, pid_ok;

  logic          st_r, dv_r, wv_r;
  logic [7:0]    ch_r, wpid_r;

  assign fifo_empty = (rd_idx_r == wr_idx_r) && (rd_ph_r == wr_ph_r);
  assign fifo_full  = (rd_idx_r == wr_idx_r) && (rd_ph_r != wr_ph_r);
  assign wr_idx_inc = (wr_idx_r == FIFO_LAST) ? '0 : wr_idx_r + FA'(1);
  assign rd_idx_inc = (rd_idx_r == FIFO_LAST) ? '0 : rd_idx_r + FA'(1);

  assign head_inc   = (head_r == WAIT_LAST) ? '0 : head_r + WA'(1);
  assign sptr_inc   = (sptr_r == WAIT_LAST) ? '0 : sptr_r + WA'(1);
  assign tail_sum   = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign tail       = (tail_sum >= TAIL_LIM) ? WA'(tail_sum - TAIL_LIM) : WA'(tail_sum);
  assign wait_full  = (count_r == WAIT_FULL);
  assign wait_raddr = cmd.pop_rd ? head_r : sptr_r;

  assign popped_ok  = ({1'b0, wait_rdata_r} < PID_LIM);
  assign pid_ok     = ({1'b0, item_r.pid} < PID_LIM);

  always_comb begin
    sts.op          = item_r.operation;
    sts.pid_none    = item_r.pid_none;
    sts.pid_ok      = pid_ok;
    sts.owner_set   = owner_set_r;
    sts.owner_match = (owner_r == item_r.pid);
    sts.fifo_empty  = fifo_empty;
    sts.wait_any    = (count_r != '0);
    sts.oper_set    = oper_set_r;
    sts.srch_hit    = cmp_vld_r && (wait_rdata_r == item_r.pid);
    sts.srch_done   = (issued_r == count_r) && !cmp_vld_r;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.push && !fifo_full) begin
      fifo_mem[wr_idx_r] <= item_r.char_value;
    end
    fifo_rdata_r <= fifo_mem[rd_idx_r];
    if (cmd.append && !wait_full) begin
      wait_mem[tail] <= item_r.pid;
    end
    wait_rdata_r <= wait_mem[wait_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
      st_r   <= 1'b0;
      dv_r   <= 1'b0;
      ch_r   <= '0;
      wv_r   <= 1'b0;
      wpid_r <= '0;
    end else begin
      if (cmd.push) begin
        wv_r   <= owner_set_r;
        wpid_r <= owner_set_r ? owner_r : '0;
      end
      if (cmd.fifo_take) begin
        dv_r <= 1'b1;
        ch_r <= fifo_rdata_r;
      end
      if (cmd.err || (cmd.pop_take && !popped_ok)) begin
        st_r <= 1'b1;
      end
    end
    if (cmd.load_out) begin
      out_r.status           <= st_r;
      out_r.data_valid       <= dv_r;
      out_r.char_out         <= ch_r;
      out_r.wake_valid       <= wv_r;
      out_r.wake_pid         <= wpid_r;
      out_r.foreground_valid <= owner_set_r;
      out_r.foreground_task  <= owner_set_r ? owner_r : '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      wr_ph_r     <= 1'b0;
      rd_idx_r    <= '0;
      rd_ph_r     <= 1'b0;
      owner_r     <= '0;
      owner_set_r <= 1'b0;
      oper_r      <= '0;
      oper_set_r  <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      sptr_r      <= '0;
      issued_r    <= '0;
      cmp_vld_r   <= 1'b0;
    end else begin
      if (cmd.push && !fifo_full) begin
        wr_idx_r <= wr_idx_inc;
        if (wr_idx_r == FIFO_LAST) begin
          wr_ph_r <= !wr_ph_r;
        end
      end
      if (cmd.fifo_take) begin
        rd_idx_r <= rd_idx_inc;
        if (rd_idx_r == FIFO_LAST) begin
          rd_ph_r <= !rd_ph_r;
        end
      end
      if (cmd.set_oper) begin
        oper_r     <= item_r.pid;
        oper_set_r <= 1'b1;
      end
      // new owner empties the fifo
      if (cmd.inst_pid || cmd.inst_oper || (cmd.pop_take && popped_ok)) begin
        owner_set_r <= 1'b1;
        rd_idx_r    <= wr_idx_r;
        rd_ph_r     <= wr_ph_r;
        if (cmd.inst_pid) begin
          owner_r <= item_r.pid;
        end else if (cmd.inst_oper) begin
          owner_r <= oper_r;
        end else begin
          owner_r <= wait_rdata_r;
        end
      end
      if (cmd.pop_take) begin
        head_r  <= head_inc;
        count_r <= count_r - CW'(1);
      end
      if (cmd.append && !wait_full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.srch_start) begin
        sptr_r    <= head_r;
        issued_r  <= '0;
        cmp_vld_r <= 1'b0;
      end else if (cmd.srch_step) begin
        if (issued_r != count_r) begin
          sptr_r    <= sptr_inc;
          issued_r  <= issued_r + CW'(1);
          cmp_vld_r <= 1'b1;
        end else begin
          cmp_vld_r <= 1'b0;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

// ----- hw/rtl/kbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// kbf_ctrl
// Controller: decodes the accepted item, sequences memory reads, the
// waiting-list search and the hand-over of the result to the output stage.
// ----------------------------------------------------------------------------
module kbf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  kbf_pkg::sts_t      sts,
  output kbf_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIFO_TAKE,
    ST_POP_TAKE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_FINISH;
        case (sts.op)
          kbf_pkg::OP_PUSH: begin
            cmd.push = 1'b1;
          end
          kbf_pkg::OP_READ: begin
            if (!sts.owner_set) begin
              if (sts.pid_ok) begin
                cmd.inst_pid = 1'b1;
              end else begin
                cmd.srch_start = 1'b1;
                state_nxt      = ST_SEARCH;
              end
            end else if (!sts.owner_match) begin
              cmd.srch_start = 1'b1;
              state_nxt      = ST_SEARCH;
            end else if (!sts.fifo_empty) begin
              state_nxt = ST_FIFO_TAKE;
            end
          end
          kbf_pkg::OP_SET_OPER: begin
            if (!sts.pid_ok || sts.oper_set) begin
              cmd.err = 1'b1;
            end else begin
              cmd.set_oper = 1'b1;
            end
          end
          kbf_pkg::OP_SET_FG: begin
            if (!sts.pid_none) begin
              if (sts.pid_ok) begin
                cmd.inst_pid = 1'b1;
              end else begin
                cmd.err = 1'b1;
              end
            end else if (sts.wait_any && !sts.oper_set) begin
              cmd.pop_rd = 1'b1;
              state_nxt  = ST_POP_TAKE;
            end else if (sts.oper_set) begin
              cmd.inst_oper = 1'b1;
            end else begin
              cmd.err = 1'b1;
            end
          end
          kbf_pkg::OP_SWITCH: begin
            cmd.inst_oper = sts.oper_set;
          end
          default: begin
            cmd.err = 1'b1;
          end
        endcase
      end
      ST_FIFO_TAKE: begin
        cmd.fifo_take = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_POP_TAKE: begin
        cmd.pop_take = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_SEARCH: begin
        if (sts.srch_hit) begin
          state_nxt = ST_FINISH;
        end else if (sts.srch_done) begin
          cmd.append = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.load_out = !out_valid_r || !out_stall;
        if (cmd.load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/keyboard_buffer_with_foreground_owner.sv -----
// ----------------------------------------------------------------------------
// keyboard_buffer_with_foreground_owner
// Each item passes IDLE (latch), DECODE and FINISH (load to the output
// register); an owner read with data adds FIFO_TAKE, a set taking a waiting
// task adds POP_TAKE, and a non-owner read adds SEARCH over the waiting list.
// One item in flight; the next is taken after the result is handed to the
// output register, which waits while out_stall holds it. Synchronous reset
// clears pointers, owner, operator, list count, search and control state only.
// ----------------------------------------------------------------------------
module keyboard_buffer_with_foreground_owner #(
  parameter int unsigned FIFO_DEPTH = kbf_pkg::KBF_FIFO_DEPTH,
  parameter int unsigned TASK_LIMIT = kbf_pkg::KBF_TASK_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kbf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kbf_pkg::out_item_t out_data
);

  kbf_pkg::cmd_t cmd;
  kbf_pkg::sts_t sts;

  kbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kbf_dpath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .TASK_LIMIT (TASK_LIMIT)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- hw/rtl/kbf_chk.sv -----
// ----------------------------------------------------------------------------
// kbf_chk
// Port-level checker for the keyboard buffer, bound to the top level.
// ----------------------------------------------------------------------------
module kbf_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input kbf_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in progress");

  // a push does not change the owner it wakes
  a_wake_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wake_valid |->
      out_data.foreground_valid && (out_data.wake_pid == out_data.foreground_task))
    else $error("wake does not name the foreground task");

  a_no_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.foreground_valid |->
      (out_data.foreground_task == 8'd0) && !out_data.data_valid)
    else $error("data or task number without an owner");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.data_valid |-> !out_data.status && !out_data.wake_valid)
    else $error("read result carries error or wake");

endmodule

bind keyboard_buffer_with_foreground_owner kbf_chk u_kbf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyboard buffer with foreground owner. A queue
// of keyboard operations (directed corner cases, then random owner sessions,
// hand-overs and noise, a waiting-list flood, a FIFO fill and an operator
// setup) feeds a valid/stall driver; every accepted operation is run through a
// behavioural model of the buffer and the owed reply is compared field by field
// with the block output.
module tb;

  localparam int unsigned DEPTH = kbf_pkg::KBF_FIFO_DEPTH;
  localparam int unsigned TASKS = kbf_pkg::KBF_TASK_LIMIT;
  localparam int unsigned PW = $clog2(DEPTH) + 1;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED = 3'd7;

  typedef struct packed {
    logic              drain;
    kbf_pkg::in_item_t item;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kbf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kbf_pkg::out_item_t out_data;

  job_t op_jobs[$];
  kbf_pkg::out_item_t owed_replies[$];
  int errors = 0;
  int n_sent = 0;
  int n_taken = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  int in_gap = 0;
  int stall_left = 0;

  // model state
  logic [7:0] fifo_mem [DEPTH];
  logic [PW-1:0] rd_ptr = '0;
  logic [PW-1:0] wr_ptr = '0;
  logic [7:0] fg_task = '0;
  logic fg_set = 1'b0;
  logic [7:0] oper_task = '0;
  logic oper_set = 1'b0;
  logic [7:0] waiters [TASKS];
  int n_waiting = 0;

  keyboard_buffer_with_foreground_owner dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  function automatic logic claim_owner(logic [7:0] t);
    if (t >= TASKS) return 1'b1;
    rd_ptr = wr_ptr;
    fg_task = t;
    fg_set = 1'b1;
    return 1'b0;
  endfunction

  function automatic void add_waiter(logic [7:0] t);
    for (int i = 0; i < n_waiting; i++)
      if (waiters[i] == t) return;
    if (n_waiting >= TASKS) return;
    waiters[n_waiting] = t;
    n_waiting++;
  endfunction

  function automatic kbf_pkg::out_item_t predict_reply(kbf_pkg::in_item_t it);
    kbf_pkg::out_item_t r;
    logic [PW-1:0] fill;
    logic [7:0] head;
    r = '0;
    fill = wr_ptr - rd_ptr;
    case (it.operation)
      kbf_pkg::OP_PUSH: begin
        if (fill < DEPTH) begin
          fifo_mem[wr_ptr % DEPTH] = it.char_value;
          wr_ptr++;
        end
        if (fg_set) begin
          r.wake_valid = 1'b1;
          r.wake_pid = fg_task;
        end
      end
      kbf_pkg::OP_READ: begin
        if (!fg_set) void'(claim_owner(it.pid));
        if (!fg_set || fg_task != it.pid) begin
          add_waiter(it.pid);
        end else if (wr_ptr != rd_ptr) begin
          r.char_out = fifo_mem[rd_ptr % DEPTH];
          r.data_valid = 1'b1;
          rd_ptr++;
        end
      end
      kbf_pkg::OP_SET_OPER: begin
        if (it.pid >= TASKS || oper_set) begin
          r.status = 1'b1;
        end else begin
          oper_task = it.pid;
          oper_set = 1'b1;
        end
      end
      kbf_pkg::OP_SET_FG: begin
        if (!it.pid_none) begin
          r.status = claim_owner(it.pid);
        end else if (n_waiting > 0 && !oper_set) begin
          head = waiters[0];
          for (int i = 0; i + 1 < n_waiting; i++) waiters[i] = waiters[i + 1];
          n_waiting--;
          r.status = claim_owner(head);
        end else if (oper_set) begin
          r.status = claim_owner(oper_task);
        end else begin
          r.status = 1'b1;
        end
      end
      kbf_pkg::OP_SWITCH: begin
        if (oper_set) r.status = claim_owner(oper_task);
      end
      default: r.status = 1'b1;
    endcase
    r.foreground_valid = fg_set;
    r.foreground_task = fg_set ? fg_task : 8'h00;
    return r;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  task automatic queue_op(input logic [2:0] op, input logic [7:0] ch, input logic [7:0] pid,
                          input logic nn);
    job_t j;
    j.item.operation = op;
    j.item.char_value = ch;
    j.item.pid = pid;
    j.item.pid_none = nn;
    j.drain = ($urandom_range(0, 39) == 0);
    op_jobs.push_back(j);
  endtask

  task automatic owner_session();
    logic [7:0] p;
    int r;
    p = 8'($urandom_range(0, TASKS - 1));
    queue_op(kbf_pkg::OP_SET_FG, rnd8(), p, 1'b0);
    repeat ($urandom_range(4, 24)) begin
      r = $urandom_range(0, 19);
      if (r < 9) queue_op(kbf_pkg::OP_PUSH, rnd8(), rnd8(), 1'($urandom_range(0, 1)));
      else if (r < 17) queue_op(kbf_pkg::OP_READ, rnd8(), p, 1'($urandom_range(0, 1)));
      else queue_op(kbf_pkg::OP_READ, rnd8(), rnd8(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic handover();
    logic [7:0] readers [6];
    int k;
    int m;
    k = $urandom_range(1, 5);
    for (int i = 0; i < k; i++) begin
      readers[i] = ($urandom_range(0, 2) == 0) ? rnd8() : 8'($urandom_range(0, TASKS - 1));
      queue_op(kbf_pkg::OP_READ, rnd8(), readers[i], 1'($urandom_range(0, 1)));
    end
    m = $urandom_range(1, k + 1);
    for (int i = 0; i < m; i++) begin
      queue_op(kbf_pkg::OP_SET_FG, rnd8(), rnd8(), 1'b1);
      repeat ($urandom_range(0, 3))
        queue_op(kbf_pkg::OP_PUSH, rnd8(), rnd8(), 1'($urandom_range(0, 1)));
      if (i < k)
        repeat ($urandom_range(1, 3))
          queue_op(kbf_pkg::OP_READ, rnd8(), readers[i], 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic noise_op(input bit oper_free);
    logic [2:0] op;
    logic [7:0] pid;
    op = 3'($urandom_range(kbf_pkg::OP_PUSH, OP_LAST_UNUSED));
    pid = rnd8();
    if (op == kbf_pkg::OP_SET_OPER && !oper_free) pid = 8'($urandom_range(TASKS, 255));
    queue_op(op, rnd8(), pid, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_mix(input int upto, input bit oper_free);
    int r;
    while (op_jobs.size() < upto) begin
      r = $urandom_range(0, 9);
      if (r < 4) owner_session();
      else if (r < 7) handover();
      else repeat ($urandom_range(1, 4)) noise_op(oper_free);
    end
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // transfer driver
  always @(negedge clk) begin
    job_t nxt;
    if (rst_n && n_sent == n_taken) begin
      if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (op_jobs.size() > 0 && !(op_jobs[0].drain && owed_replies.size() != 0)) begin
        nxt = op_jobs.pop_front();
        in_data <= nxt.item;
        in_valid <= 1'b1;
        n_sent++;
        in_gap = (calm_in || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 63) == 0) calm_out = !calm_out;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm_out && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    kbf_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        owed_replies.push_back(predict_reply(in_data));
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        if (owed_replies.size() == 0) begin
          $display("%0t ns: reply with nothing owed, expected none, got %p", $time, out_data);
          errors++;
        end else begin
          want = owed_replies.pop_front();
          cmp_field("status", 8'(want.status), 8'(out_data.status));
          cmp_field("data_valid", 8'(want.data_valid), 8'(out_data.data_valid));
          cmp_field("char_out", want.char_out, out_data.char_out);
          cmp_field("wake_valid", 8'(want.wake_valid), 8'(out_data.wake_valid));
          cmp_field("wake_pid", want.wake_pid, out_data.wake_pid);
          cmp_field("foreground_valid", 8'(want.foreground_valid), 8'(out_data.foreground_valid));
          cmp_field("foreground_task", want.foreground_task, out_data.foreground_task);
        end
      end
    end
  end

  initial begin
    int perm [TASKS];
    int j;
    int t;
    logic [7:0] p;
    for (int i = 0; i < DEPTH; i++) fifo_mem[i] = '0;
    for (int i = 0; i < TASKS; i++) waiters[i] = '0;

    // corner cases
    queue_op(kbf_pkg::OP_PUSH, 8'h00, 8'h00, 1'b0);
    queue_op(kbf_pkg::OP_READ, 8'h00, 8'd200, 1'b0);
    queue_op(kbf_pkg::OP_READ, 8'h00, 8'd5, 1'b0);
    queue_op(kbf_pkg::OP_PUSH, 8'hff, 8'h00, 1'b0);
    queue_op(kbf_pkg::OP_PUSH, 8'ha5, 8'h00, 1'b0);
    repeat (3) queue_op(kbf_pkg::OP_READ, 8'h00, 8'd5, 1'b0);
    repeat (2) queue_op(kbf_pkg::OP_READ, 8'h00, 8'd9, 1'b0);
    queue_op(kbf_pkg::OP_SET_FG, 8'h00, 8'(TASKS), 1'b0);
    queue_op(kbf_pkg::OP_SET_FG, 8'h00, 8'hff, 1'b0);
    repeat (3) queue_op(kbf_pkg::OP_SET_FG, 8'h00, 8'h00, 1'b1);
    queue_op(kbf_pkg::OP_SWITCH, 8'h00, 8'h00, 1'b0);
    queue_op(kbf_pkg::OP_SET_OPER, 8'h00, 8'(TASKS), 1'b0);
    queue_op(kbf_pkg::OP_SET_OPER, 8'h00, 8'hff, 1'b0);
    queue_op(kbf_pkg::OP_SET_FG, 8'h00, 8'(TASKS - 1), 1'b0);
    queue_op(kbf_pkg::OP_SET_FG, 8'hff, 8'h00, 1'b0);
    queue_op(OP_FIRST_UNUSED, 8'hff, 8'hff, 1'b1);
    queue_op(OP_FIRST_UNUSED + 3'd1, 8'h00, 8'h00, 1'b0);
    queue_op(OP_LAST_UNUSED, 8'hff, 8'hff, 1'b1);
    queue_op(kbf_pkg::OP_PUSH, 8'hff, 8'h00, 1'b1);

    random_mix(150, 1'b0);

    // flood the waiting list past its size
    p = 8'($urandom_range(0, TASKS - 1));
    queue_op(kbf_pkg::OP_SET_FG, rnd8(), p, 1'b0);
    for (int i = 0; i < TASKS; i++) perm[i] = i;
    for (int i = TASKS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < TASKS; i++)
      if (perm[i] != p)
        queue_op(kbf_pkg::OP_READ, rnd8(), 8'(perm[i]), 1'($urandom_range(0, 1)));
    repeat (3) queue_op(kbf_pkg::OP_READ, rnd8(), 8'($urandom_range(TASKS, 255)), 1'b0);
    repeat (3) queue_op(kbf_pkg::OP_SET_FG, rnd8(), rnd8(), 1'b1);

    random_mix(300, 1'b0);

    // fill the fifo and push past full
    p = 8'($urandom_range(0, TASKS - 1));
    queue_op(kbf_pkg::OP_SET_FG, rnd8(), p, 1'b0);
    repeat (DEPTH + 2) queue_op(kbf_pkg::OP_PUSH, rnd8(), rnd8(), 1'($urandom_range(0, 1)));
    repeat (3) queue_op(kbf_pkg::OP_READ, rnd8(), p, 1'b0);
    repeat (2) queue_op(kbf_pkg::OP_PUSH, rnd8(), rnd8(), 1'b0);

    random_mix(560, 1'b0);

    // operator setup; the first valid set is sent only once everything before it has been answered
    queue_op(kbf_pkg::OP_SET_OPER, rnd8(), 8'($urandom_range(TASKS, 255)), 1'b0);
    queue_op(kbf_pkg::OP_SET_OPER, rnd8(), 8'($urandom_range(0, TASKS - 1)), 1'b0);
    op_jobs[$].drain = 1'b1;
    queue_op(kbf_pkg::OP_SET_OPER, rnd8(), 8'($urandom_range(0, TASKS - 1)), 1'b0);
    queue_op(kbf_pkg::OP_SWITCH, rnd8(), rnd8(), 1'b0);
    queue_op(kbf_pkg::OP_SET_FG, rnd8(), rnd8(), 1'b1);

    random_mix(650, 1'b1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (op_jobs.size() != 0 || in_valid || owed_replies.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
